// ===== hdl/mwo_pkg.sv =====
// Shared widths, constants and the arctangent table of the mecanum odometry block.
package mwo_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ANGLE_BITS_DEF   = 32;

    // serial multiplier: multiplier bits, multiplicand bits, product bits
    localparam int MUL_A_W   = 41;
    localparam int MUL_B_W   = 44;
    localparam int MUL_P_W   = 85;
    localparam int MUL_CNT_W = 6;

    localparam logic [MUL_CNT_W-1:0] N_SPEED = 6'd18;
    localparam logic [MUL_CNT_W-1:0] N_COEF  = 6'd16;
    localparam logic [MUL_CNT_W-1:0] N_VEL   = 6'd24;
    localparam logic [MUL_CNT_W-1:0] N_DT    = 6'd16;
    localparam logic [MUL_CNT_W-1:0] N_SCALE = 6'd41;

    localparam int CORDIC_W = 34;
    localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 34'sd652032874;

    localparam logic [MUL_A_W-1:0] HEADING_SCALE = 41'd1467945251647;

    // position divisor is 2^20 * 15625
    localparam int DIV_BITS = 40;
    localparam int REM_W    = 14;
    localparam logic [REM_W:0] DIV_CONST = 15'd15625;

    localparam int CFG_IDX_W = 4;
    localparam logic [CFG_IDX_W-1:0] REG_WHEEL_RADIUS  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INV_TRACK_SUM = 4'd1;
    localparam logic [15:0] WHEEL_RADIUS_RST  = 16'd8323;
    localparam logic [15:0] INV_TRACK_SUM_RST = 16'd7447;

    typedef enum logic [3:0] {
        OP_VX  = 4'd0,
        OP_VY  = 4'd1,
        OP_RI  = 4'd2,
        OP_WZ  = 4'd3,
        OP_XC  = 4'd4,
        OP_YS  = 4'd5,
        OP_XS  = 4'd6,
        OP_YC  = 4'd7,
        OP_PX  = 4'd8,
        OP_PY  = 4'd9,
        OP_MAG = 4'd10,
        OP_HDG = 4'd11
    } t_op;

    function automatic logic [29:0] atan_at(input logic [4:0] idx);
        logic [29:0] v;
        case (idx)
            5'd0:    v = 30'h20000000;
            5'd1:    v = 30'h12E4051E;
            5'd2:    v = 30'h09FB385B;
            5'd3:    v = 30'h051111D4;
            5'd4:    v = 30'h028B0D43;
            5'd5:    v = 30'h0145D7E1;
            5'd6:    v = 30'h00A2F61E;
            5'd7:    v = 30'h00517C55;
            5'd8:    v = 30'h0028BE53;
            5'd9:    v = 30'h00145F2F;
            5'd10:   v = 30'h000A2F98;
            5'd11:   v = 30'h000517CC;
            5'd12:   v = 30'h00028BE6;
            5'd13:   v = 30'h000145F3;
            5'd14:   v = 30'h0000A2F9;
            5'd15:   v = 30'h0000517C;
            5'd16:   v = 30'h000028BE;
            5'd17:   v = 30'h0000145F;
            5'd18:   v = 30'h00000A2F;
            5'd19:   v = 30'h00000517;
            5'd20:   v = 30'h0000028B;
            5'd21:   v = 30'h00000145;
            5'd22:   v = 30'h000000A2;
            5'd23:   v = 30'h00000051;
            5'd24:   v = 30'h00000028;
            5'd25:   v = 30'h00000014;
            5'd26:   v = 30'h0000000A;
            5'd27:   v = 30'h00000005;
            5'd28:   v = 30'h00000002;
            5'd29:   v = 30'h00000001;
            default: v = 30'h0;
        endcase
        return v;
    endfunction

endpackage

// ===== hdl/mecanum_wheel_odometry.sv =====
// Mecanum odometry top level: kinematics, heading rotation, pose integration sequencer.
// Throughput: one request at a time; the next is taken once the sequencer is back in idle,
// even while the previous result still waits in the output register.
// Run time is set by the bit-serial multiplier (twelve products, one bit per cycle),
// the serial divider for position (one pass for each axis) and two CORDIC passes.
// Synchronous active-low reset clears pose, heading, registers to defaults and control.
module mecanum_wheel_odometry import mwo_pkg::*; #(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
    parameter int ANGLE_BITS   = ANGLE_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [15:0]          i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic signed [15:0]   i_speed_front_left,
    input  logic signed [15:0]   i_speed_front_right,
    input  logic signed [15:0]   i_speed_rear_left,
    input  logic signed [15:0]   i_speed_rear_right,
    input  logic [15:0]          i_elapsed_us,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic signed [31:0]   o_pos_x,
    output logic signed [31:0]   o_pos_y,
    output logic signed [15:0]   o_quat_w,
    output logic signed [15:0]   o_quat_z,
    output logic signed [31:0]   o_vel_x,
    output logic signed [31:0]   o_vel_y,
    output logic signed [31:0]   o_yaw_rate
);

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_MSTART = 7'b0000010,
        ST_MWAIT  = 7'b0000100,
        ST_CSTART = 7'b0001000,
        ST_CWAIT  = 7'b0010000,
        ST_DIV    = 7'b0100000,
        ST_DONE   = 7'b1000000
    } t_state;

    t_state                  r_state;
    t_op                     r_op;
    logic                    r_cpass;
    logic [MUL_CNT_W-1:0]    r_dcnt;
    logic                    r_out_valid;
    logic [15:0]             r_radius;
    logic [15:0]             r_its;
    logic signed [31:0]      r_pose_x;
    logic signed [31:0]      r_pose_y;
    logic [ANGLE_BITS-1:0]   r_heading;

    logic signed [18:0]      r_s1, r_s2, r_s3;
    logic [15:0]             r_dt;
    logic signed [31:0]      r_vx, r_vy, r_wz;
    logic [31:0]             r_ri;
    logic signed [CORDIC_W-1:0] r_c, r_s;
    logic signed [15:0]      r_qw, r_qz;
    logic signed [59:0]      r_t1;
    logic signed [43:0]      r_wx, r_wy;
    logic [43:0]             r_mag;
    logic [DIV_BITS-1:0]     r_dq;
    logic [REM_W-1:0]        r_drem;
    logic                    r_dneg;

    logic signed [31:0]      r_o_pos_x, r_o_pos_y, r_o_vx, r_o_vy, r_o_wz;
    logic signed [15:0]      r_o_qw, r_o_qz;

    logic                    w_in_acc;
    logic signed [18:0]      w_w0, w_w1, w_w2, w_w3;
    logic [31:0]             w_phase;
    logic [31:0]             w_cphase;
    logic                    w_mstart, w_cstart;
    logic                    w_mdone, w_cdone;
    logic [MUL_P_W-1:0]      w_prod;
    logic [MUL_CNT_W-1:0]    w_nbits;
    logic [MUL_A_W-1:0]      w_mplier;
    logic [MUL_B_W-1:0]      w_mcand;
    logic                    w_neg;
    logic signed [MUL_P_W:0] w_sprod;
    logic signed [MUL_P_W:0] w_sh10, w_sh22;
    logic signed [59:0]      w_sp60, w_diff, w_sum, w_diff_sh, w_sum_sh;
    logic signed [CORDIC_W-1:0] w_ccos, w_csin;
    logic signed [CORDIC_W-1:0] w_hc_sh, w_hs_sh;
    logic signed [15:0]      w_qw, w_qz;
    logic [18:0]             w_a_s1, w_a_s2, w_a_s3;
    logic [31:0]             w_a_vx, w_a_vy, w_a_wz;
    logic [CORDIC_W-1:0]     w_a_c, w_a_s;
    logic [43:0]             w_a_wx, w_a_wy;
    logic [MUL_P_W-1:0]      w_dsh;
    logic [ANGLE_BITS-1:0]   w_delta;
    logic [REM_W:0]          w_rsh;
    logic                    w_ge;
    logic [REM_W:0]          w_rnext;
    logic [DIV_BITS-1:0]     w_qnext;
    logic signed [41:0]      w_qs, w_pold, w_pnew;
    logic signed [31:0]      w_pclamp;

    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;

    assign w_w0 = {{3{i_speed_front_left[15]}}, i_speed_front_left};
    assign w_w1 = {{3{i_speed_front_right[15]}}, i_speed_front_right};
    assign w_w2 = {{3{i_speed_rear_left[15]}}, i_speed_rear_left};
    assign w_w3 = {{3{i_speed_rear_right[15]}}, i_speed_rear_right};

    // phase of the heading: half the heading as a full-circle angle
    generate
        if (ANGLE_BITS >= 32) begin : g_phase_dn
            assign w_phase = r_heading[ANGLE_BITS-1 -: 32];
        end else begin : g_phase_up
            assign w_phase = {r_heading, {(32-ANGLE_BITS){1'b0}}};
        end
    endgenerate

    assign w_cphase = r_cpass ? {w_phase[30:0], 1'b0} : w_phase;
    assign w_mstart = (r_state == ST_MSTART);
    assign w_cstart = (r_state == ST_CSTART);

    // magnitudes of the operands
    always_comb begin
        w_a_s1 = r_s1[18] ? 19'(-r_s1) : 19'(r_s1);
        w_a_s2 = r_s2[18] ? 19'(-r_s2) : 19'(r_s2);
        w_a_s3 = r_s3[18] ? 19'(-r_s3) : 19'(r_s3);
        w_a_vx = r_vx[31] ? 32'(-r_vx) : 32'(r_vx);
        w_a_vy = r_vy[31] ? 32'(-r_vy) : 32'(r_vy);
        w_a_wz = r_wz[31] ? 32'(-r_wz) : 32'(r_wz);
        w_a_c  = r_c[CORDIC_W-1] ? CORDIC_W'(-r_c) : CORDIC_W'(r_c);
        w_a_s  = r_s[CORDIC_W-1] ? CORDIC_W'(-r_s) : CORDIC_W'(r_s);
        w_a_wx = r_wx[43] ? 44'(-r_wx) : 44'(r_wx);
        w_a_wy = r_wy[43] ? 44'(-r_wy) : 44'(r_wy);
    end

    // operand select per product
    always_comb begin
        w_nbits  = N_COEF;
        w_mplier = '0;
        w_mcand  = '0;
        w_neg    = 1'b0;
        case (r_op)
            OP_VX: begin
                w_nbits = N_SPEED; w_mplier = MUL_A_W'(w_a_s1);
                w_mcand = MUL_B_W'(r_radius); w_neg = r_s1[18];
            end
            OP_VY: begin
                w_nbits = N_SPEED; w_mplier = MUL_A_W'(w_a_s2);
                w_mcand = MUL_B_W'(r_radius); w_neg = r_s2[18];
            end
            OP_RI: begin
                w_nbits = N_COEF; w_mplier = MUL_A_W'(r_its);
                w_mcand = MUL_B_W'(r_radius);
            end
            OP_WZ: begin
                w_nbits = N_SPEED; w_mplier = MUL_A_W'(w_a_s3);
                w_mcand = MUL_B_W'(r_ri); w_neg = r_s3[18];
            end
            OP_XC: begin
                w_nbits = N_VEL; w_mplier = MUL_A_W'(w_a_vx);
                w_mcand = MUL_B_W'(w_a_c); w_neg = r_vx[31] ^ r_c[CORDIC_W-1];
            end
            OP_YS: begin
                w_nbits = N_VEL; w_mplier = MUL_A_W'(w_a_vy);
                w_mcand = MUL_B_W'(w_a_s); w_neg = r_vy[31] ^ r_s[CORDIC_W-1];
            end
            OP_XS: begin
                w_nbits = N_VEL; w_mplier = MUL_A_W'(w_a_vx);
                w_mcand = MUL_B_W'(w_a_s); w_neg = r_vx[31] ^ r_s[CORDIC_W-1];
            end
            OP_YC: begin
                w_nbits = N_VEL; w_mplier = MUL_A_W'(w_a_vy);
                w_mcand = MUL_B_W'(w_a_c); w_neg = r_vy[31] ^ r_c[CORDIC_W-1];
            end
            OP_PX: begin
                w_nbits = N_DT; w_mplier = MUL_A_W'(r_dt); w_mcand = w_a_wx;
            end
            OP_PY: begin
                w_nbits = N_DT; w_mplier = MUL_A_W'(r_dt); w_mcand = w_a_wy;
            end
            OP_MAG: begin
                w_nbits = N_DT; w_mplier = MUL_A_W'(r_dt); w_mcand = MUL_B_W'(w_a_wz);
            end
            OP_HDG: begin
                w_nbits = N_SCALE; w_mplier = HEADING_SCALE; w_mcand = r_mag;
            end
            default: begin
                w_nbits = N_COEF;
            end
        endcase
    end

    mwo_mul u_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_mstart),
        .i_nbits  (w_nbits),
        .i_mplier (w_mplier),
        .i_mcand  (w_mcand),
        .o_done   (w_mdone),
        .o_prod   (w_prod)
    );

    mwo_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_cstart),
        .i_phase (w_cphase),
        .o_done  (w_cdone),
        .o_cos   (w_ccos),
        .o_sin   (w_csin)
    );

    // signed product and its scalings
    always_comb begin
        w_sprod   = w_neg ? -$signed({1'b0, w_prod}) : $signed({1'b0, w_prod});
        w_sh10    = w_sprod >>> 10;
        w_sh22    = w_sprod >>> 22;
        w_sp60    = w_sprod[59:0];
        w_diff    = r_t1 - w_sp60;
        w_sum     = r_t1 + w_sp60;
        w_diff_sh = w_diff >>> 16;
        w_sum_sh  = w_sum >>> 16;
        w_dsh     = w_prod >> (80 - ANGLE_BITS);
        w_delta   = w_dsh[ANGLE_BITS-1:0];
    end

    // quaternion: drop 16 fraction bits, clamp to 16 bits
    always_comb begin
        w_hc_sh = w_ccos >>> 16;
        w_hs_sh = w_csin >>> 16;
        if (w_hc_sh > 34'sd32767) begin
            w_qw = 16'sh7FFF;
        end else if (w_hc_sh < -34'sd32768) begin
            w_qw = 16'sh8000;
        end else begin
            w_qw = w_hc_sh[15:0];
        end
        if (w_hs_sh > 34'sd32767) begin
            w_qz = 16'sh7FFF;
        end else if (w_hs_sh < -34'sd32768) begin
            w_qz = 16'sh8000;
        end else begin
            w_qz = w_hs_sh[15:0];
        end
    end

    // restoring divide by 15625, one quotient bit per cycle
    always_comb begin
        w_rsh   = {r_drem, r_dq[DIV_BITS-1]};
        w_ge    = (w_rsh >= DIV_CONST);
        w_rnext = w_ge ? (w_rsh - DIV_CONST) : w_rsh;
        w_qnext = {r_dq[DIV_BITS-2:0], w_ge};
        w_qs    = r_dneg ? -$signed({2'b00, w_qnext}) : $signed({2'b00, w_qnext});
        w_pold  = (r_op == OP_PX) ? 42'(r_pose_x) : 42'(r_pose_y);
        w_pnew  = w_pold + w_qs;
        if (w_pnew > 42'sh7FFFFFFF) begin
            w_pclamp = 32'sh7FFFFFFF;
        end else if (w_pnew < -42'sh80000000) begin
            w_pclamp = 32'sh80000000;
        end else begin
            w_pclamp = w_pnew[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_op        <= OP_VX;
            r_cpass     <= 1'b0;
            r_dcnt      <= '0;
            r_out_valid <= 1'b0;
            r_radius    <= WHEEL_RADIUS_RST;
            r_its       <= INV_TRACK_SUM_RST;
            r_pose_x    <= '0;
            r_pose_y    <= '0;
            r_heading   <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == REG_WHEEL_RADIUS) begin
                    r_radius <= i_cfg_data;
                end else if (i_cfg_index == REG_INV_TRACK_SUM) begin
                    r_its <= i_cfg_data;
                end
            end
            // drop a taken result unless a new one loads in its place
            if (r_out_valid && !i_out_stall && r_state != ST_DONE) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (w_in_acc) begin
                        r_op    <= OP_VX;
                        r_state <= ST_MSTART;
                    end
                end
                ST_MSTART: begin
                    r_state <= ST_MWAIT;
                end
                ST_MWAIT: begin
                    if (w_mdone) begin
                        case (r_op) inside
                            OP_WZ: begin
                                r_cpass <= 1'b0;
                                r_state <= ST_CSTART;
                            end
                            OP_PX, OP_PY: begin
                                r_dcnt  <= MUL_CNT_W'(DIV_BITS);
                                r_state <= ST_DIV;
                            end
                            OP_HDG: begin
                                if (r_wz[31]) begin
                                    r_heading <= r_heading - w_delta;
                                end else begin
                                    r_heading <= r_heading + w_delta;
                                end
                                r_state <= ST_DONE;
                            end
                            default: begin
                                r_op    <= t_op'(r_op + 4'd1);
                                r_state <= ST_MSTART;
                            end
                        endcase
                    end
                end
                ST_CSTART: begin
                    r_state <= ST_CWAIT;
                end
                ST_CWAIT: begin
                    if (w_cdone) begin
                        if (!r_cpass) begin
                            r_cpass <= 1'b1;
                            r_state <= ST_CSTART;
                        end else begin
                            r_op    <= OP_XC;
                            r_state <= ST_MSTART;
                        end
                    end
                end
                ST_DIV: begin
                    r_dcnt <= r_dcnt - 1'b1;
                    if (r_dcnt == MUL_CNT_W'(1)) begin
                        if (r_op == OP_PX) begin
                            r_pose_x <= w_pclamp;
                        end else begin
                            r_pose_y <= w_pclamp;
                        end
                        r_op    <= t_op'(r_op + 4'd1);
                        r_state <= ST_MSTART;
                    end
                end
                ST_DONE: begin
                    // hold until the output register is free
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid <= 1'b1;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_s1 <= w_w0 + w_w1 + w_w2 + w_w3;
            r_s2 <= -w_w0 + w_w1 + w_w2 - w_w3;
            r_s3 <= -w_w0 + w_w1 - w_w2 + w_w3;
            r_dt <= i_elapsed_us;
        end
        if (r_state == ST_MWAIT && w_mdone) begin
            case (r_op)
                OP_VX:   r_vx  <= w_sh10[31:0];
                OP_VY:   r_vy  <= w_sh10[31:0];
                OP_RI:   r_ri  <= w_prod[31:0];
                OP_WZ:   r_wz  <= w_sh22[31:0];
                OP_XC:   r_t1  <= w_sp60;
                OP_YS:   r_wx  <= w_diff_sh[43:0];
                OP_XS:   r_t1  <= w_sp60;
                OP_YC:   r_wy  <= w_sum_sh[43:0];
                OP_PX: begin
                    r_dq   <= w_prod[59:20];
                    r_drem <= '0;
                    r_dneg <= r_wx[43];
                end
                OP_PY: begin
                    r_dq   <= w_prod[59:20];
                    r_drem <= '0;
                    r_dneg <= r_wy[43];
                end
                OP_MAG:  r_mag <= w_prod[43:0];
                default: r_mag <= r_mag;
            endcase
        end
        if (r_state == ST_DIV) begin
            r_dq   <= w_qnext;
            r_drem <= w_rnext[REM_W-1:0];
        end
        if (r_state == ST_CWAIT && w_cdone) begin
            if (!r_cpass) begin
                r_qw <= w_qw;
                r_qz <= w_qz;
            end else begin
                r_c <= w_ccos;
                r_s <= w_csin;
            end
        end
        if (r_state == ST_DONE && (!r_out_valid || !i_out_stall)) begin
            r_o_pos_x <= r_pose_x;
            r_o_pos_y <= r_pose_y;
            r_o_qw    <= r_qw;
            r_o_qz    <= r_qz;
            r_o_vx    <= r_vx;
            r_o_vy    <= r_vy;
            r_o_wz    <= r_wz;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_pos_x     = r_o_pos_x;
    assign o_pos_y     = r_o_pos_y;
    assign o_quat_w    = r_o_qw;
    assign o_quat_z    = r_o_qz;
    assign o_vel_x     = r_o_vx;
    assign o_vel_y     = r_o_vy;
    assign o_yaw_rate  = r_o_wz;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> o_in_stall)
        else $error("request accepted but sequencer not busy");

    a_mul_done_expected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mdone |-> (r_state == ST_MWAIT))
        else $error("multiplier finished outside its wait state");

    a_cordic_done_expected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cdone |-> (r_state == ST_CWAIT))
        else $error("cordic finished outside its wait state");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> (r_out_valid && $stable(r_o_pos_x)))
        else $error("waiting result lost or overwritten");

endmodule

// ===== hdl/mwo_mul.sv =====
// Bit-serial shift-add multiplier on unsigned magnitudes, one multiplier bit per cycle.
module mwo_mul import mwo_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [MUL_CNT_W-1:0] i_nbits,
    input  logic [MUL_A_W-1:0]   i_mplier,
    input  logic [MUL_B_W-1:0]   i_mcand,
    output logic                 o_done,
    output logic [MUL_P_W-1:0]   o_prod
);

    logic [MUL_CNT_W-1:0] r_cnt;
    logic                 r_done;
    logic [MUL_A_W-1:0]   r_mq;
    logic [MUL_P_W-1:0]   r_mc;
    logic [MUL_P_W-1:0]   r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= i_nbits;
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == MUL_CNT_W'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mq  <= i_mplier;
            r_mc  <= MUL_P_W'(i_mcand);
            r_acc <= '0;
        end else if (r_cnt != '0) begin
            if (r_mq[0]) begin
                r_acc <= r_acc + r_mc;
            end
            r_mc <= {r_mc[MUL_P_W-2:0], 1'b0};
            r_mq <= {1'b0, r_mq[MUL_A_W-1:1]};
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

// ===== hdl/mwo_cordic.sv =====
// Iterative rotation-mode CORDIC: cos and sin in Q4.30 of a 32 bit phase (2^32 is a full circle).
module mwo_cordic import mwo_pkg::*; #(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [31:0]                i_phase,
    output logic                       o_done,
    output logic signed [CORDIC_W-1:0] o_cos,
    output logic signed [CORDIC_W-1:0] o_sin
);

    localparam int IW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;

    logic                       r_busy;
    logic                       r_done;
    logic [IW-1:0]              r_i;
    logic                       r_flip;
    logic signed [CORDIC_W-1:0] r_x;
    logic signed [CORDIC_W-1:0] r_y;
    logic signed [CORDIC_W-1:0] r_p;

    logic signed [CORDIC_W-1:0] w_p0;
    logic signed [CORDIC_W-1:0] w_pf;
    logic                       w_flip;
    logic signed [CORDIC_W-1:0] w_xs;
    logic signed [CORDIC_W-1:0] w_ys;
    logic signed [CORDIC_W-1:0] w_at;

    // fold into the right half plane, negate both results later
    always_comb begin
        w_p0   = {{(CORDIC_W-32){i_phase[31]}}, i_phase};
        w_pf   = w_p0;
        w_flip = 1'b0;
        if (w_p0 > 34'sh040000000) begin
            w_pf   = w_p0 - 34'sh080000000;
            w_flip = 1'b1;
        end else if (w_p0 < -34'sh040000000) begin
            w_pf   = w_p0 + 34'sh080000000;
            w_flip = 1'b1;
        end
    end

    assign w_xs = r_x >>> r_i;
    assign w_ys = r_y >>> r_i;
    assign w_at = $signed({{(CORDIC_W-30){1'b0}}, atan_at(5'(r_i))});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_i    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_i    <= '0;
            end else if (r_busy) begin
                r_i <= r_i + 1'b1;
                if (r_i == IW'(CORDIC_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x    <= CORDIC_GAIN;
            r_y    <= '0;
            r_p    <= w_pf;
            r_flip <= w_flip;
        end else if (r_busy) begin
            if (!r_p[CORDIC_W-1]) begin
                r_x <= r_x - w_ys;
                r_y <= r_y + w_xs;
                r_p <= r_p - w_at;
            end else begin
                r_x <= r_x + w_ys;
                r_y <= r_y - w_xs;
                r_p <= r_p + w_at;
            end
        end
    end

    assign o_done = r_done;
    assign o_cos  = r_flip ? -r_x : r_x;
    assign o_sin  = r_flip ? -r_y : r_y;

endmodule
